FILE: rtl/ulle_pkg.sv
package ulle_pkg;

  localparam int unsigned ValW = 32;
  localparam int unsigned OpW  = 3;

  typedef enum logic [OpW-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_VAL   = 3'd3,
    OP_DEL_AT    = 3'd4,
    OP_SEARCH    = 3'd5,
    OP_READ      = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    SH_HOLD,
    SH_INS,
    SH_DEL
  } shift_e;

  // Broadcast to every cell in the apply cycle.
  typedef struct packed {
    shift_e            kind;
    logic [ValW-1:0]   value;
  } cmd_t;

endpackage

FILE: rtl/ulle_cell.sv
module ulle_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned PW  = 5,
  parameter int unsigned IW  = 4
) (
  input  logic                      clk_i,
  input  ulle_pkg::cmd_t            cmd_i,
  input  logic [PW-1:0]             ipos_i,    // index of insert or delete
  input  logic [PW-1:0]             count_i,
  input  logic [ulle_pkg::ValW-1:0] key_i,     // search key
  input  logic [PW-1:0]             rpos_i,    // read index
  input  logic [ulle_pkg::ValW-1:0] left_i,    // entry of the cell in front
  input  logic [ulle_pkg::ValW-1:0] right_i,   // entry of the cell behind
  input  logic                      found_i,
  input  logic [IW-1:0]             idx_i,
  input  logic [ulle_pkg::ValW-1:0] rd_i,
  output logic [ulle_pkg::ValW-1:0] entry_o,
  output logic                      found_o,
  output logic [IW-1:0]             idx_o,
  output logic [ulle_pkg::ValW-1:0] rd_o
);

  localparam logic [PW-1:0] IdxP = PW'(IDX);
  localparam logic [IW-1:0] IdxI = IW'(IDX);

  logic [ulle_pkg::ValW-1:0] entry_q, entry_d;
  logic                      match;

  always_comb begin
    entry_d = entry_q;
    unique case (cmd_i.kind)
      ulle_pkg::SH_INS: begin
        if (IdxP > ipos_i) begin
          entry_d = left_i;
        end else if (IdxP == ipos_i) begin
          entry_d = cmd_i.value;
        end
      end
      ulle_pkg::SH_DEL: begin
        if (IdxP >= ipos_i) begin
          entry_d = right_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // Only live entries take part in the search.
  assign match   = (entry_q == key_i) && (IdxP < count_i);
  assign found_o = found_i | match;
  assign idx_o   = (match && !found_i) ? IdxI : idx_i;
  assign rd_o    = (IdxP == rpos_i) ? entry_q : rd_i;
  assign entry_o = entry_q;

endmodule

FILE: rtl/unique_ordered_list_engine_core.sv
// The core takes a new item only after the last one is applied: in IDLE it
// searches the cell chain as the item is accepted, in APPLY it shifts the
// cells and loads the output register. A result still held on the output
// stalls the APPLY step.
// Reset: entry count and handshake state clear; cell contents stay undefined
// until written and need no clearing pass.
module unique_ordered_list_engine_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // op[2:0], value[34:3], position[39:35]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // ok[0], result_value[32:1],
                                      // result_index[36:33], entry_count[41:37]
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned PW = (CW > 5) ? CW : 5;
  localparam int unsigned VW = ulle_pkg::ValW;

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_e;

  state_e state_q;

  // Captured item and search results.
  logic [ulle_pkg::OpW-1:0] op_q;
  logic [VW-1:0]            val_q;
  logic [PW-1:0]            pos_q;
  logic                     hit_q;
  logic [IW-1:0]            hidx_q;
  logic [VW-1:0]            rdv_q;
  logic [CW-1:0]            count_q, count_d;

  // Output register.
  logic                     mvalid_q;
  logic                     ok_q;
  logic [VW-1:0]            rval_q;
  logic [3:0]               ridx_q;
  logic [4:0]               ocnt_q;

  // Input beat fields.
  logic [ulle_pkg::OpW-1:0] in_op;
  logic [VW-1:0]            in_val;
  logic [4:0]               in_pos;
  assign in_op  = s_axis_tdata[2:0];
  assign in_val = s_axis_tdata[34:3];
  assign in_pos = s_axis_tdata[39:35];

  logic in_fire, apply_fire;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign apply_fire    = (state_q == ST_APPLY) && (!mvalid_q || m_axis_tready);

  // Cell chain: entries shift between neighbors; search and read results
  // ripple from the front cell to the back.
  logic [VW-1:0] entry  [CAPACITY];
  logic          found  [CAPACITY+1];
  logic [IW-1:0] idxc   [CAPACITY+1];
  logic [VW-1:0] rdc    [CAPACITY+1];
  ulle_pkg::cmd_t cmd;
  logic [PW-1:0]  ipos;
  logic [PW-1:0]  count_p;

  assign count_p = PW'(count_q);
  assign found[0] = 1'b0;
  assign idxc[0]  = '0;
  assign rdc[0]   = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VW-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid
      assign left = entry[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = entry[g+1];
    end
    ulle_cell #(
      .IDX (g),
      .PW  (PW),
      .IW  (IW)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .ipos_i  (ipos),
      .count_i (count_p),
      .key_i   (in_val),
      .rpos_i  (PW'(in_pos)),
      .left_i  (left),
      .right_i (right),
      .found_i (found[g]),
      .idx_i   (idxc[g]),
      .rd_i    (rdc[g]),
      .entry_o (entry[g]),
      .found_o (found[g+1]),
      .idx_o   (idxc[g+1]),
      .rd_o    (rdc[g+1])
    );
  end

  // Decide the operation from the captured search results.
  logic          ok;
  logic          full;
  logic [VW-1:0] rval;
  logic [3:0]    ridx;
  logic [PW-1:0] hidx_p;

  assign full   = (count_q == CW'(CAPACITY));
  assign hidx_p = PW'(hidx_q);

  always_comb begin
    ok         = 1'b0;
    rval       = '0;
    ridx       = '0;
    ipos       = '0;
    cmd.kind   = ulle_pkg::SH_HOLD;
    cmd.value  = val_q;
    count_d    = count_q;
    unique case (op_q)
      ulle_pkg::OP_INS_FRONT: begin
        ok = !full && !hit_q;
        ipos = '0;
      end
      ulle_pkg::OP_INS_BACK: begin
        ok = !full && !hit_q;
        ipos = count_p;
      end
      ulle_pkg::OP_INS_AT: begin
        ok = (count_q != '0) && !full && !hit_q && (pos_q <= count_p);
        ipos = pos_q;
      end
      ulle_pkg::OP_DEL_VAL: begin
        ok = hit_q;
        ipos = hidx_p;
      end
      ulle_pkg::OP_DEL_AT: begin
        ok = pos_q < count_p;
        ipos = pos_q;
      end
      ulle_pkg::OP_SEARCH: begin
        ok = hit_q;
        if (hit_q) begin
          ridx = 4'(32'(hidx_q));
        end
      end
      ulle_pkg::OP_READ: begin
        ok = pos_q < count_p;
        if (ok) begin
          rval = rdv_q;
        end
      end
      default: ok = 1'b0;
    endcase
    // Drive the cells and the count only on a successful apply.
    if (apply_fire && ok) begin
      priority if (op_q == ulle_pkg::OP_INS_FRONT || op_q == ulle_pkg::OP_INS_BACK ||
                   op_q == ulle_pkg::OP_INS_AT) begin
        cmd.kind = ulle_pkg::SH_INS;
        count_d  = count_q + CW'(1);
      end else if (op_q == ulle_pkg::OP_DEL_VAL || op_q == ulle_pkg::OP_DEL_AT) begin
        cmd.kind = ulle_pkg::SH_DEL;
        count_d  = count_q - CW'(1);
      end else begin
        cmd.kind = ulle_pkg::SH_HOLD;
      end
    end
  end

  // Hold state, count and the output beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      mvalid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      // Load a new beat on apply, otherwise drop the taken one.
      if (apply_fire) begin
        mvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        mvalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (apply_fire) begin
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload registers: captured item and result fields.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= in_op;
      val_q  <= in_val;
      pos_q  <= PW'(in_pos);
      hit_q  <= found[CAPACITY];
      hidx_q <= idxc[CAPACITY];
      rdv_q  <= rdc[CAPACITY];
    end
    if (apply_fire) begin
      ok_q   <= ok;
      rval_q <= rval;
      ridx_q <= ridx;
      ocnt_q <= 5'(32'(count_d));
    end
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {6'd0, ocnt_q, ridx_q, rval_q, ok_q};

endmodule
